/* src/dcl_pkg.sv */
package dcl_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int DIMS       = 4;

   localparam int PIDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int DIM_W   = (DIMS > 1) ? $clog2(DIMS) : 1;
   localparam int COORD_W = 16;
   localparam int EPS_W   = 36;
   localparam int ADIM_W  = 3;
   localparam int LABEL_W = 11;
   localparam int KIND_W  = 2;
   localparam int SQ_W    = 2 * (COORD_W + 1);
   localparam int SUM_W   = SQ_W + ((DIMS > 1) ? $clog2(DIMS) : 0);
   localparam int CMP_W   = (SUM_W > EPS_W) ? SUM_W : EPS_W;
   localparam int ENTRY_W = KIND_W + LABEL_W;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_RUN  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [1:0] CSR_EPS     = 2'd0;
   localparam logic [1:0] CSR_MINPTS  = 2'd1;
   localparam logic [1:0] CSR_DIMS    = 2'd2;

   localparam logic [KIND_W-1:0] KIND_NOISE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CORE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BORDER = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   localparam logic [LABEL_W-1:0] LABEL_NONE = '1;

   localparam logic [1:0] SCAN_CLEAR  = 2'd0;
   localparam logic [1:0] SCAN_COUNT  = 2'd1;
   localparam logic [1:0] SCAN_EXPAND = 2'd2;
   localparam logic [1:0] SCAN_TALLY  = 2'd3;

   typedef struct packed {
      logic       load_wr;
      logic       read_req;
      logic       run_init;
      logic       scan_start;
      logic [1:0] scan_mode;
      logic       fetch_i;
      logic       next_i;
      logic       center_i;
      logic       center_q;
      logic       mark_noise;
      logic       mark_core;
      logic       queue_reset;
      logic       pop;
      logic       next_cluster;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic i_done;
      logic i_classified;
      logic is_core;
      logic queue_empty;
   } dp_status_type;

endpackage

/* src/dcl_ctrl.sv */
module dcl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_cmd,
   input  dcl_pkg::dp_status_type st,
   output dcl_pkg::dp_cmd_type   cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_CLEAR_GO   = 4'd1;
   localparam logic [3:0] S_CLEAR_WAIT = 4'd2;
   localparam logic [3:0] S_NEXT_I     = 4'd3;
   localparam logic [3:0] S_WAIT_I     = 4'd4;
   localparam logic [3:0] S_CNT_GO     = 4'd5;
   localparam logic [3:0] S_CNT_WAIT   = 4'd6;
   localparam logic [3:0] S_DECIDE     = 4'd7;
   localparam logic [3:0] S_EXP_GO     = 4'd8;
   localparam logic [3:0] S_EXP_WAIT   = 4'd9;
   localparam logic [3:0] S_POP        = 4'd10;
   localparam logic [3:0] S_POP_WAIT   = 4'd11;
   localparam logic [3:0] S_TALLY_GO   = 4'd12;
   localparam logic [3:0] S_TALLY_WAIT = 4'd13;
   localparam logic [3:0] S_DONE       = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       running_ff, running_in;
   logic       seed_ff, seed_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      running_in   = running_ff;
      seed_in      = seed_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_cmd)
                  dcl_pkg::CMD_LOAD: begin
                     cmd.load_wr  = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  dcl_pkg::CMD_READ: begin
                     cmd.read_req = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  dcl_pkg::CMD_RUN: begin
                     cmd.run_init = 1'b1;
                     running_in   = 1'b1;
                     state_in     = S_CLEAR_GO;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_CLEAR_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = dcl_pkg::SCAN_CLEAR;
            state_in       = S_CLEAR_WAIT;
         end
         S_CLEAR_WAIT: begin
            if (st.scan_done) state_in = running_ff ? S_NEXT_I : S_IDLE;
         end
         S_NEXT_I: begin
            if (st.i_done) begin
               state_in = S_TALLY_GO;
            end else begin
               cmd.fetch_i = 1'b1;
               state_in    = S_WAIT_I;
            end
         end
         S_WAIT_I: begin
            if (st.i_classified) begin
               cmd.next_i = 1'b1;
               state_in   = S_NEXT_I;
            end else begin
               cmd.center_i = 1'b1;
               seed_in      = 1'b1;
               state_in     = S_CNT_GO;
            end
         end
         S_CNT_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = dcl_pkg::SCAN_COUNT;
            state_in       = S_CNT_WAIT;
         end
         S_CNT_WAIT: begin
            if (st.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (st.is_core) begin
               cmd.mark_core   = 1'b1;
               cmd.queue_reset = seed_ff;
               state_in        = S_EXP_GO;
            end else if (seed_ff) begin
               cmd.mark_noise = 1'b1;
               cmd.next_i     = 1'b1;
               state_in       = S_NEXT_I;
            end else begin
               state_in = S_POP;
            end
         end
         S_EXP_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = dcl_pkg::SCAN_EXPAND;
            state_in       = S_EXP_WAIT;
         end
         S_EXP_WAIT: begin
            if (st.scan_done) state_in = S_POP;
         end
         S_POP: begin
            if (st.queue_empty) begin
               cmd.next_cluster = 1'b1;
               cmd.next_i       = 1'b1;
               state_in         = S_NEXT_I;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_POP_WAIT;
            end
         end
         S_POP_WAIT: begin
            cmd.center_q = 1'b1;
            seed_in      = 1'b0;
            state_in     = S_CNT_GO;
         end
         S_TALLY_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = dcl_pkg::SCAN_TALLY;
            state_in       = S_TALLY_WAIT;
         end
         S_TALLY_WAIT: begin
            if (st.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            running_in   = 1'b0;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR_GO;   // stores come up cleared
         running_ff   <= 1'b0;
         seed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/dcl_datapath.sv */
module dcl_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [dcl_pkg::EPS_W-1:0]            csr_wdata,
   input  logic [dcl_pkg::PIDX_W-1:0]           req_point_index,
   input  logic [1:0]                           req_dim_index,
   input  logic signed [dcl_pkg::COORD_W-1:0]   req_coord,
   input  logic [dcl_pkg::CNT_W-1:0]            req_point_count,
   input  dcl_pkg::dp_cmd_type                  cmd,
   output dcl_pkg::dp_status_type               st,
   output logic signed [dcl_pkg::LABEL_W-1:0]   rsp_cluster_label,
   output logic [dcl_pkg::KIND_W-1:0]           rsp_point_kind,
   output logic [dcl_pkg::CNT_W-1:0]            rsp_cluster_count,
   output logic [dcl_pkg::CNT_W-1:0]            rsp_noise_count,
   output logic [dcl_pkg::CNT_W-1:0]            rsp_core_count
);

   localparam int PW = dcl_pkg::PIDX_W;
   localparam int CW = dcl_pkg::CNT_W;
   localparam int XW = dcl_pkg::COORD_W;
   localparam int EW = dcl_pkg::ENTRY_W;
   localparam logic [CW-1:0] NMAX = CW'(dcl_pkg::MAX_POINTS);

   // configuration
   logic [dcl_pkg::EPS_W-1:0]  eps_ff;
   logic [CW-1:0]              minpts_ff;
   logic [dcl_pkg::ADIM_W-1:0] adims_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff    <= dcl_pkg::EPS_W'(65536);
         minpts_ff <= CW'(5);
         adims_ff  <= dcl_pkg::ADIM_W'(4);
      end else if (csr_we) begin
         case (csr_index)
            dcl_pkg::CSR_EPS:    eps_ff    <= csr_wdata;
            dcl_pkg::CSR_MINPTS: minpts_ff <= csr_wdata[CW-1:0];
            dcl_pkg::CSR_DIMS:   adims_ff  <= csr_wdata[dcl_pkg::ADIM_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] minp;
   logic [4:0]    ndims;
   assign minp = (minpts_ff < CW'(2)) ? CW'(2) : minpts_ff;
   always_comb begin
      if (adims_ff == '0) ndims = 5'd1;
      else if (5'(adims_ff) > 5'(dcl_pkg::DIMS)) ndims = 5'(dcl_pkg::DIMS);
      else ndims = 5'(adims_ff);
   end

   // run bookkeeping
   logic [CW-1:0] n_ff, i_ff, cid_ff, noise_ff, core_ff, cnt_ff, head_ff, tail_ff;
   logic [PW-1:0] center_ff;

   // scan engine
   logic          scan_active_ff;
   logic [1:0]    scan_mode_ff;
   logic [CW-1:0] scan_j_ff, scan_limit;
   logic          issue;
   logic          v1_ff, v2_ff, v3_ff;
   logic [PW-1:0] j1_ff, j2_ff, j3_ff;
   logic [EW-1:0] ent2_ff, ent3_ff;
   logic          near3_ff;

   assign scan_limit = (scan_mode_ff == dcl_pkg::SCAN_CLEAR) ? NMAX : n_ff;
   assign issue      = scan_active_ff && (scan_j_ff < scan_limit);

   // coordinate store: one memory per dimension, two read ports
   logic [XW-1:0] coord_mem [dcl_pkg::DIMS][dcl_pkg::MAX_POINTS];
   logic signed [XW-1:0] ca_ff [dcl_pkg::DIMS];
   logic signed [XW-1:0] cb_ff [dcl_pkg::DIMS];

   for (genvar d = 0; d < dcl_pkg::DIMS; d++) begin : g_coord
      always_ff @(posedge clock) begin
         if (cmd.load_wr && (req_dim_index == 2'(d)))
            coord_mem[d][req_point_index] <= req_coord;
         ca_ff[d] <= coord_mem[d][center_ff];
         cb_ff[d] <= coord_mem[d][scan_j_ff[PW-1:0]];
      end
   end

   // kind and cluster store, entry = {kind, label}
   logic [EW-1:0] lbl_mem [dcl_pkg::MAX_POINTS];
   logic [EW-1:0] lbl_rd_ff;
   logic [PW-1:0] lbl_raddr, lbl_waddr;
   logic [EW-1:0] lbl_wdata;
   logic          lbl_we;
   logic          exp_hit;

   assign exp_hit = v3_ff && near3_ff && (scan_mode_ff == dcl_pkg::SCAN_EXPAND)
                    && (ent3_ff[dcl_pkg::LABEL_W-1:0] == dcl_pkg::LABEL_NONE);

   always_comb begin
      lbl_we    = 1'b0;
      lbl_waddr = scan_j_ff[PW-1:0];
      lbl_wdata = {dcl_pkg::KIND_NONE, dcl_pkg::LABEL_NONE};
      if (issue && scan_mode_ff == dcl_pkg::SCAN_CLEAR) begin
         lbl_we = 1'b1;
      end else if (exp_hit) begin
         lbl_we    = 1'b1;
         lbl_waddr = j3_ff;
         lbl_wdata = {dcl_pkg::KIND_BORDER, cid_ff};
      end else if (cmd.mark_noise) begin
         lbl_we    = 1'b1;
         lbl_waddr = i_ff[PW-1:0];
         lbl_wdata = {dcl_pkg::KIND_NOISE, dcl_pkg::LABEL_NONE};
      end else if (cmd.mark_core) begin
         lbl_we    = 1'b1;
         lbl_waddr = center_ff;
         lbl_wdata = {dcl_pkg::KIND_CORE, cid_ff};
      end
   end

   always_comb begin
      if (scan_active_ff) lbl_raddr = scan_j_ff[PW-1:0];
      else if (cmd.fetch_i) lbl_raddr = i_ff[PW-1:0];
      else lbl_raddr = req_point_index;
   end

   always_ff @(posedge clock) begin
      if (lbl_we) lbl_mem[lbl_waddr] <= lbl_wdata;
      lbl_rd_ff <= lbl_mem[lbl_raddr];
   end

   // breadth-first work queue
   logic [PW-1:0] q_mem [dcl_pkg::MAX_POINTS];
   logic [PW-1:0] q_rd_ff;

   always_ff @(posedge clock) begin
      if (exp_hit) q_mem[tail_ff[PW-1:0]] <= j3_ff;
      q_rd_ff <= q_mem[head_ff[PW-1:0]];
   end

   // distance pipeline: read, square, sum and compare
   logic [dcl_pkg::SQ_W-1:0] sq2_ff [dcl_pkg::DIMS];
   logic [dcl_pkg::SUM_W-1:0] dist_sum;

   for (genvar d = 0; d < dcl_pkg::DIMS; d++) begin : g_sq
      logic signed [XW:0]                  diff;
      logic signed [dcl_pkg::SQ_W-1:0]     sq;
      assign diff = (XW+1)'(ca_ff[d]) - (XW+1)'(cb_ff[d]);
      assign sq   = diff * diff;
      always_ff @(posedge clock) sq2_ff[d] <= $unsigned(sq);
   end

   always_comb begin
      dist_sum = '0;
      for (int d = 0; d < dcl_pkg::DIMS; d++)
         if (5'(d) < ndims) dist_sum = dist_sum + dcl_pkg::SUM_W'(sq2_ff[d]);
   end

   always_ff @(posedge clock) begin
      j1_ff    <= scan_j_ff[PW-1:0];
      j2_ff    <= j1_ff;
      j3_ff    <= j2_ff;
      ent2_ff  <= lbl_rd_ff;
      ent3_ff  <= ent2_ff;
      near3_ff <= dcl_pkg::CMP_W'(dist_sum) <= dcl_pkg::CMP_W'(eps_ff);
   end

   logic rd_sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_active_ff <= 1'b0;
         scan_mode_ff   <= dcl_pkg::SCAN_CLEAR;
         scan_j_ff      <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         n_ff           <= '0;
         i_ff           <= '0;
         cid_ff         <= '0;
         noise_ff       <= '0;
         core_ff        <= '0;
         cnt_ff         <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         center_ff      <= '0;
         rd_sel_ff      <= 1'b0;
      end else begin
         rd_sel_ff <= cmd.read_req;
         v1_ff     <= issue && (scan_mode_ff != dcl_pkg::SCAN_CLEAR);
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;

         if (cmd.scan_start) begin
            scan_active_ff <= 1'b1;
            scan_mode_ff   <= cmd.scan_mode;
            scan_j_ff      <= '0;
            cnt_ff         <= '0;
         end else if (scan_active_ff) begin
            if (issue) scan_j_ff <= scan_j_ff + CW'(1);
            else scan_active_ff <= 1'b0;
         end

         if (cmd.run_init) begin
            n_ff     <= (req_point_count > NMAX) ? NMAX : req_point_count;
            i_ff     <= '0;
            cid_ff   <= '0;
            noise_ff <= '0;
            core_ff  <= '0;
         end
         if (cmd.next_i) i_ff <= i_ff + CW'(1);
         if (cmd.next_cluster) cid_ff <= cid_ff + CW'(1);
         if (cmd.center_i) center_ff <= i_ff[PW-1:0];
         if (cmd.center_q) center_ff <= q_rd_ff;

         if (v3_ff && near3_ff && scan_mode_ff == dcl_pkg::SCAN_COUNT)
            cnt_ff <= cnt_ff + CW'(1);
         if (v3_ff && scan_mode_ff == dcl_pkg::SCAN_TALLY) begin
            if (ent3_ff[EW-1 -: dcl_pkg::KIND_W] == dcl_pkg::KIND_NOISE)
               noise_ff <= noise_ff + CW'(1);
            if (ent3_ff[EW-1 -: dcl_pkg::KIND_W] == dcl_pkg::KIND_CORE)
               core_ff <= core_ff + CW'(1);
         end

         if (cmd.queue_reset || cmd.run_init) begin
            head_ff <= '0;
            tail_ff <= '0;
         end else begin
            if (exp_hit) tail_ff <= tail_ff + CW'(1);
            if (cmd.pop) head_ff <= head_ff + CW'(1);
         end
      end
   end

   assign st.scan_done    = !(scan_active_ff || v1_ff || v2_ff || v3_ff);
   assign st.i_done       = (i_ff >= n_ff);
   assign st.i_classified = (lbl_rd_ff[EW-1 -: dcl_pkg::KIND_W] != dcl_pkg::KIND_NONE);
   assign st.is_core      = (cnt_ff >= minp);
   assign st.queue_empty  = (head_ff == tail_ff);

   assign rsp_cluster_label = rd_sel_ff ? $signed(lbl_rd_ff[dcl_pkg::LABEL_W-1:0]) : '0;
   assign rsp_point_kind    = rd_sel_ff ? lbl_rd_ff[EW-1 -: dcl_pkg::KIND_W]
                                        : dcl_pkg::KIND_NOISE;
   assign rsp_cluster_count = cid_ff;
   assign rsp_noise_count   = noise_ff;
   assign rsp_core_count    = core_ff;

   // queue never underflows and holds each point at most once
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("queue head passed tail");
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= n_ff) else $error("queue grew beyond point count");
   a_scan_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> st.scan_done) else $error("scan started while busy");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !st.queue_empty) else $error("pop from empty queue");

endmodule

/* src/density_cluster_labeler.sv */
// Load and read transactions are taken every cycle while busy is low, and each
// answers with one rsp_valid strobe in the next cycle; the receiver cannot
// stall, so results must be captured in that cycle. A run transaction raises
// busy and first clears the whole label store (the same pass runs after
// reset). Then the distance checks run as passes over the n points through
// the read, square and sum-and-compare pipeline: one pass per unvisited seed,
// one count pass per queued point reached, one expand pass per core point
// reached, and a final tally pass. Run time is set by the single distance
// pipeline.
module density_cluster_labeler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_cmd,
   input  logic [dcl_pkg::PIDX_W-1:0]           req_point_index,
   input  logic [1:0]                           req_dim_index,
   input  logic signed [dcl_pkg::COORD_W-1:0]   req_coord,
   input  logic [dcl_pkg::CNT_W-1:0]            req_point_count,
   output logic                                 rsp_valid,
   output logic signed [dcl_pkg::LABEL_W-1:0]   rsp_cluster_label,
   output logic [dcl_pkg::KIND_W-1:0]           rsp_point_kind,
   output logic [dcl_pkg::CNT_W-1:0]            rsp_cluster_count,
   output logic [dcl_pkg::CNT_W-1:0]            rsp_noise_count,
   output logic [dcl_pkg::CNT_W-1:0]            rsp_core_count,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [dcl_pkg::EPS_W-1:0]            csr_wdata
);

   dcl_pkg::dp_cmd_type    cmd;
   dcl_pkg::dp_status_type st;

   dcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .st        (st),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dcl_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_point_index   (req_point_index),
      .req_dim_index     (req_dim_index),
      .req_coord         (req_coord),
      .req_point_count   (req_point_count),
      .cmd               (cmd),
      .st                (st),
      .rsp_cluster_label (rsp_cluster_label),
      .rsp_point_kind    (rsp_point_kind),
      .rsp_cluster_count (rsp_cluster_count),
      .rsp_noise_count   (rsp_noise_count),
      .rsp_core_count    (rsp_core_count)
   );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam int         NUM_ROUNDS     = 6;
   localparam int         WATCHDOG_LIMIT = 8_000_000;

   typedef struct {
      logic [dcl_pkg::LABEL_W-1:0] label;
      logic [dcl_pkg::KIND_W-1:0]  kind;
      logic [dcl_pkg::CNT_W-1:0]   clusters;
      logic [dcl_pkg::CNT_W-1:0]   noise;
      logic [dcl_pkg::CNT_W-1:0]   cores;
   } label_result_type;

   class cluster_scoreboard;
      int                          coord_mem[dcl_pkg::MAX_POINTS*dcl_pkg::DIMS];
      logic [dcl_pkg::KIND_W-1:0]  kind_mem[dcl_pkg::MAX_POINTS];
      int                          label_mem[dcl_pkg::MAX_POINTS];
      logic [dcl_pkg::EPS_W-1:0]   eps_sq;
      logic [dcl_pkg::CNT_W-1:0]   min_pts;
      logic [dcl_pkg::ADIM_W-1:0]  dims_reg;
      int                          n_clusters;
      int                          n_noise;
      int                          n_core;
      label_result_type            expected_q[$];
      int                          errors;

      function new();
         eps_sq   = dcl_pkg::EPS_W'(65536);
         min_pts  = dcl_pkg::CNT_W'(5);
         dims_reg = dcl_pkg::ADIM_W'(4);
         foreach (coord_mem[i]) coord_mem[i] = 0;
         clear_labels();
         n_clusters = 0;
         n_noise    = 0;
         n_core     = 0;
         errors     = 0;
      endfunction

      function void clear_labels();
         foreach (kind_mem[i]) begin
            kind_mem[i]  = dcl_pkg::KIND_NONE;
            label_mem[i] = -1;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function void set_reg(logic [1:0] idx, logic [dcl_pkg::EPS_W-1:0] val);
         case (idx)
            dcl_pkg::CSR_EPS:    eps_sq   = val;
            dcl_pkg::CSR_MINPTS: min_pts  = val[dcl_pkg::CNT_W-1:0];
            dcl_pkg::CSR_DIMS:   dims_reg = val[dcl_pkg::ADIM_W-1:0];
            default: ;
         endcase
      endfunction

      function bit is_near(int a, int b, int nd);
         longint unsigned sum;
         longint          diff;
         sum = 0;
         for (int d = 0; d < nd; d++) begin
            diff = coord_mem[a*dcl_pkg::DIMS+d] - coord_mem[b*dcl_pkg::DIMS+d];
            sum += diff * diff;
         end
         return sum <= {28'd0, eps_sq};
      endfunction

      function int neighbors(int p, int n, int nd);
         int c;
         c = 0;
         for (int j = 0; j < n; j++) if (is_near(p, j, nd)) c++;
         return c;
      endfunction

      // seed goes through the same queue as reached points; it is already core
      function void cluster_points(int n);
         int nd;
         int minp;
         int cid;
         int cur;
         int q[$];
         nd   = (dims_reg == 0) ? 1 :
                (dims_reg > dcl_pkg::DIMS) ? dcl_pkg::DIMS : int'(dims_reg);
         minp = (min_pts < 2) ? 2 : int'(min_pts);
         cid  = 0;
         clear_labels();
         for (int i = 0; i < n; i++) begin
            if (kind_mem[i] != dcl_pkg::KIND_NONE) continue;
            if (neighbors(i, n, nd) < minp) begin
               kind_mem[i] = dcl_pkg::KIND_NOISE;
               continue;
            end
            kind_mem[i]  = dcl_pkg::KIND_CORE;
            label_mem[i] = cid;
            q.delete();
            q.push_back(i);
            while (q.size() > 0) begin
               cur = q.pop_front();
               if (cur != i) begin
                  if (neighbors(cur, n, nd) < minp) continue;
                  kind_mem[cur] = dcl_pkg::KIND_CORE;
               end
               for (int j = 0; j < n; j++) begin
                  if (label_mem[j] == -1 && is_near(cur, j, nd)) begin
                     label_mem[j] = cid;
                     kind_mem[j]  = dcl_pkg::KIND_BORDER;
                     q.push_back(j);
                  end
               end
            end
            cid++;
         end
         n_clusters = cid;
         n_noise    = 0;
         n_core     = 0;
         for (int i = 0; i < n; i++) begin
            if (kind_mem[i] == dcl_pkg::KIND_NOISE) n_noise++;
            if (kind_mem[i] == dcl_pkg::KIND_CORE) n_core++;
         end
      endfunction

      function void note_input(logic [1:0] cmd, logic [dcl_pkg::PIDX_W-1:0] idx,
                               logic [1:0] dim, logic signed [dcl_pkg::COORD_W-1:0] coord,
                               logic [dcl_pkg::CNT_W-1:0] cnt);
         label_result_type r;
         r.label = '0;
         r.kind  = '0;
         case (cmd)
            dcl_pkg::CMD_LOAD: coord_mem[idx*dcl_pkg::DIMS+dim] = coord;
            dcl_pkg::CMD_RUN:
               cluster_points((cnt > dcl_pkg::MAX_POINTS) ? dcl_pkg::MAX_POINTS : int'(cnt));
            dcl_pkg::CMD_READ: begin
               r.label = dcl_pkg::LABEL_W'(label_mem[idx]);
               r.kind  = kind_mem[idx];
            end
            default: ;
         endcase
         r.clusters = dcl_pkg::CNT_W'(n_clusters);
         r.noise    = dcl_pkg::CNT_W'(n_noise);
         r.cores    = dcl_pkg::CNT_W'(n_core);
         expected_q.push_back(r);
      endfunction

      task check_result(logic [dcl_pkg::LABEL_W-1:0] label, logic [dcl_pkg::KIND_W-1:0] kind,
                        logic [dcl_pkg::CNT_W-1:0] clusters, logic [dcl_pkg::CNT_W-1:0] noise,
                        logic [dcl_pkg::CNT_W-1:0] cores);
         label_result_type e;
         if (expected_q.size() == 0) begin
            report("result with no transaction outstanding");
         end else begin
            e = expected_q.pop_front();
            if (label !== e.label)
               report($sformatf("cluster_label got %0h exp %0h", label, e.label));
            if (kind !== e.kind)
               report($sformatf("point_kind got %0d exp %0d", kind, e.kind));
            if (clusters !== e.clusters)
               report($sformatf("cluster_count got %0d exp %0d", clusters, e.clusters));
            if (noise !== e.noise)
               report($sformatf("noise_count got %0d exp %0d", noise, e.noise));
            if (cores !== e.cores)
               report($sformatf("core_count got %0d exp %0d", cores, e.cores));
         end
      endtask
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [1:0]                         req_cmd;
   logic [dcl_pkg::PIDX_W-1:0]         req_point_index;
   logic [1:0]                         req_dim_index;
   logic signed [dcl_pkg::COORD_W-1:0] req_coord;
   logic [dcl_pkg::CNT_W-1:0]          req_point_count;
   logic                               rsp_valid;
   logic signed [dcl_pkg::LABEL_W-1:0] rsp_cluster_label;
   logic [dcl_pkg::KIND_W-1:0]         rsp_point_kind;
   logic [dcl_pkg::CNT_W-1:0]          rsp_cluster_count;
   logic [dcl_pkg::CNT_W-1:0]          rsp_noise_count;
   logic [dcl_pkg::CNT_W-1:0]          rsp_core_count;
   logic                               csr_we;
   logic [1:0]                         csr_index;
   logic [dcl_pkg::EPS_W-1:0]          csr_wdata;

   cluster_scoreboard sb = new();
   int                idle_pct;
   int                idle_cycles;

   always #10 clock = ~clock;

   density_cluster_labeler i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_point_index   (req_point_index),
      .req_dim_index     (req_dim_index),
      .req_coord         (req_coord),
      .req_point_count   (req_point_count),
      .rsp_valid         (rsp_valid),
      .rsp_cluster_label (rsp_cluster_label),
      .rsp_point_kind    (rsp_point_kind),
      .rsp_cluster_count (rsp_cluster_count),
      .rsp_noise_count   (rsp_noise_count),
      .rsp_core_count    (rsp_core_count),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (csr_we) sb.set_reg(csr_index, csr_wdata);
         if (rsp_valid)
            sb.check_result(rsp_cluster_label, rsp_point_kind, rsp_cluster_count,
                            rsp_noise_count, rsp_core_count);
         if (start && !busy)
            sb.note_input(req_cmd, req_point_index, req_dim_index, req_coord,
                          req_point_count);
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // returns at the edge that accepted the transaction; start stays high
   task automatic send_txn(input logic [1:0] cmd, input int idx, input int dim,
                           input int coord, input int cnt);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 4);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_cmd         <= cmd;
      req_point_index <= dcl_pkg::PIDX_W'(idx);
      req_dim_index   <= 2'(dim);
      req_coord       <= dcl_pkg::COORD_W'(coord);
      req_point_count <= dcl_pkg::CNT_W'(cnt);
      do @(posedge clock); while (busy);
   endtask

   task automatic csr_write(input logic [1:0] idx, input longint val);
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0 || busy);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= dcl_pkg::EPS_W'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic noise_txn();
      case ($urandom_range(0, 2))
         0: send_txn(dcl_pkg::CMD_LOAD, $urandom_range(0, 1023), $urandom_range(0, 3),
                     $urandom, $urandom);
         1: send_txn(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
         default: send_txn(dcl_pkg::CMD_READ, $urandom_range(0, 1023), $urandom, $urandom,
                           $urandom);
      endcase
   endtask

   initial begin : stimulus
      int                        m;
      int                        spread;
      int                        n_centers;
      int                        grp;
      int                        val;
      int                        sel;
      int                        centers[4][4];
      logic [dcl_pkg::EPS_W-1:0] eps_val;
      logic [dcl_pkg::CNT_W-1:0] minp_val;
      logic [dcl_pkg::CNT_W-1:0] cnt;

      start           <= 1'b0;
      req_cmd         <= dcl_pkg::CMD_LOAD;
      req_point_index <= '0;
      req_dim_index   <= '0;
      req_coord       <= '0;
      req_point_count <= '0;
      csr_we          <= 1'b0;
      csr_index       <= dcl_pkg::CSR_EPS;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      repeat (11) @(posedge clock);
      reset    <= 1'b0;
      idle_pct = 24;

      // directed: reads before any run, empty run, coordinate extremes,
      // duplicate points at eps zero, min_points below two
      send_txn(dcl_pkg::CMD_READ, 0, 0, 0, 0);
      send_txn(dcl_pkg::CMD_READ, 1023, 0, 0, 0);
      send_txn(dcl_pkg::CMD_RUN, 0, 0, 0, 0);
      csr_write(dcl_pkg::CSR_DIMS, 1);
      csr_write(dcl_pkg::CSR_EPS, 0);
      csr_write(dcl_pkg::CSR_MINPTS, 0);
      send_txn(dcl_pkg::CMD_LOAD, 0, 0, 16'h8000, 0);
      send_txn(dcl_pkg::CMD_LOAD, 1, 0, 16'h8000, 0);
      send_txn(dcl_pkg::CMD_LOAD, 2, 0, 16'h7FFF, 0);
      send_txn(dcl_pkg::CMD_LOAD, 3, 0, 16'h7FFF, 0);
      send_txn(dcl_pkg::CMD_LOAD, 4, 0, 16'h0000, 0);
      send_txn(dcl_pkg::CMD_LOAD, 5, 0, 16'h0001, 0);
      send_txn(dcl_pkg::CMD_LOAD, 6, 0, 16'h0002, 0);
      send_txn(dcl_pkg::CMD_RUN, 0, 0, 0, 6);
      send_txn(dcl_pkg::CMD_READ, 0, 0, 0, 0);
      send_txn(dcl_pkg::CMD_READ, 2, 0, 0, 0);
      send_txn(dcl_pkg::CMD_READ, 4, 0, 0, 0);
      send_txn(dcl_pkg::CMD_READ, 6, 0, 0, 0);
      send_txn(CMD_UNUSED, 3, 1, 16'h1234, 7);
      // point 4 is noise when visited, then picked up as border by point 5
      csr_write(dcl_pkg::CSR_EPS, 1);
      csr_write(dcl_pkg::CSR_MINPTS, 3);
      send_txn(dcl_pkg::CMD_RUN, 0, 0, 0, 7);
      send_txn(dcl_pkg::CMD_READ, 4, 0, 0, 0);
      send_txn(dcl_pkg::CMD_READ, 5, 0, 0, 0);
      send_txn(dcl_pkg::CMD_READ, 6, 0, 0, 0);

      for (int rnd = 0; rnd < NUM_ROUNDS; rnd++) begin
         idle_pct = (rnd < NUM_ROUNDS / 3) ? 24 : (rnd < 2 * NUM_ROUNDS / 3) ? 80 : 0;
         m         = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                 : $urandom_range(2, 20);
         spread    = $urandom_range(0, 300);
         n_centers = $urandom_range(1, 4);
         foreach (centers[c, d]) centers[c][d] = $urandom_range(0, 65535) - 32768;
         sel = $urandom_range(0, 9);
         case (sel)
            0:       eps_val = '0;
            1:       eps_val = '1;
            2:       eps_val = dcl_pkg::EPS_W'({$urandom, $urandom});
            default: eps_val = dcl_pkg::EPS_W'(spread * spread * $urandom_range(1, 8));
         endcase
         sel = $urandom_range(0, 9);
         case (sel)
            0:       minp_val = '0;
            1:       minp_val = dcl_pkg::CNT_W'(1);
            2:       minp_val = dcl_pkg::CNT_W'(2047);
            3:       minp_val = dcl_pkg::CNT_W'($urandom_range(0, 2047));
            default: minp_val = dcl_pkg::CNT_W'($urandom_range(2, 6));
         endcase
         csr_write(dcl_pkg::CSR_EPS, eps_val);
         csr_write(dcl_pkg::CSR_MINPTS, minp_val);
         csr_write(dcl_pkg::CSR_DIMS, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                                  : $urandom_range(1, 4));
         for (int p = 0; p < m; p++) begin
            grp = $urandom_range(0, n_centers - 1);
            for (int d = 0; d < dcl_pkg::DIMS; d++) begin
               val = centers[grp][d] + $urandom_range(0, 2 * spread) - spread;
               send_txn(dcl_pkg::CMD_LOAD, p, d, val, 0);
               if ($urandom_range(0, 19) == 0) noise_txn();
            end
         end
         cnt = dcl_pkg::CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, m) : m);
         send_txn(dcl_pkg::CMD_RUN, 0, 0, 0, cnt);
         repeat (m / 2 + 2) begin
            send_txn(dcl_pkg::CMD_READ, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                                    : $urandom_range(0, m + 1),
                     0, 0, 0);
         end
      end

      // full-size run: all points distinct enough to stay noise, count saturates
      idle_pct = 0;
      csr_write(dcl_pkg::CSR_DIMS, 0);
      csr_write(dcl_pkg::CSR_EPS, 0);
      csr_write(dcl_pkg::CSR_MINPTS, 1024);
      for (int p = 0; p < dcl_pkg::MAX_POINTS; p++)
         send_txn(dcl_pkg::CMD_LOAD, p, 0, $urandom, 0);
      send_txn(dcl_pkg::CMD_RUN, 0, 0, 0, 32'h780 | $urandom_range(0, 127));
      send_txn(dcl_pkg::CMD_READ, 1023, 0, 0, 0);
      send_txn(dcl_pkg::CMD_READ, $urandom_range(0, 1023), 0, 0, 0);

      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

/* sim.f */
src/dcl_pkg.sv
src/dcl_ctrl.sv
src/dcl_datapath.sv
src/density_cluster_labeler.sv
tb/sv/tb_top.sv
